// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the frame sync block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, muted while the synchronous reset is asserted.
`define HTFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that is also evaluated during reset.
`define HTFS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/htfs_pkg.sv
// Shared types, sizes and codes of the header/trailer frame sync block.
package htfs_pkg;

  // Frame and mark limits.
  localparam int MAX_FRAME = 64;
  localparam int MAX_MARK  = 8;

  // Widths; the address and mark index widths are derived from the limits.
  localparam int ADDR_W   = $clog2(MAX_FRAME);
  localparam int CNT_W    = 7;
  localparam int MIDX_W   = (MAX_MARK > 1) ? $clog2(MAX_MARK) : 1;
  localparam int BYTE_W   = 8;
  localparam int MARKS_W  = 64;
  localparam int LEN_W    = 4;
  localparam int POS_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTES   = 3'd0,
    CFG_HEADER_LENGTH  = 3'd1,
    CFG_TRAILER_BYTES  = 3'd2,
    CFG_TRAILER_LENGTH = 3'd3,
    CFG_FRAME_LENGTH   = 3'd4
  } cfg_idx_t;

  // Input request payload.
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              chunk_end;
  } in_t;

  // Result request payload.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic              frame_last;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_READ,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;
    logic rd_start;
    logic rd_next;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic frame_done;
    logic rd_last;
  } sts_t;

endpackage

// File: hw/rtl/htfs_ram.sv
// Generic memory with one write port and one registered read port.
module htfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

// File: hw/rtl/htfs_ctrl.sv
// Controller of the frame sync block: input gating and frame dump sequencing.
module htfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  htfs_pkg::sts_t sts,
  output htfs_pkg::cmd_t cmd
);

  import htfs_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   take;

  // An input byte is taken only while collecting.
  assign take = in_valid && (state_r == ST_ACCEPT);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACCEPT: begin
        if (take && sts.frame_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall && sts.rd_last) begin
          state_nxt = ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall     = (state_r != ST_ACCEPT);
    out_valid    = (state_r == ST_EMIT);
    cmd.take     = take;
    cmd.rd_start = (state_r == ST_READ);
    cmd.rd_next  = (state_r == ST_EMIT) && !out_stall && !sts.rd_last;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/htfs_dp.sv
// Datapath of the frame sync block: configuration, mark checks, frame store.
module htfs_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write,
  input  logic [htfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [htfs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  htfs_pkg::in_t                      in_data,
  output htfs_pkg::out_t                     out_data,
  input  htfs_pkg::cmd_t                     cmd,
  output htfs_pkg::sts_t                     sts
);

  import htfs_pkg::*;

  logic [MARKS_W-1:0] hdr_bytes_r;
  logic [LEN_W-1:0]   hdr_len_r;
  logic [MARKS_W-1:0] trl_bytes_r;
  logic [LEN_W-1:0]   trl_len_r;
  logic [CNT_W-1:0]   frm_len_r;

  logic [CNT_W-1:0]   byte_count_r;
  logic [CNT_W-1:0]   byte_count_nxt;
  logic               drop_r;
  logic               drop_nxt;
  logic [ADDR_W-1:0]  rd_idx_r;
  logic [ADDR_W-1:0]  rd_idx_nxt;

  logic [CNT_W-1:0]   fl;
  logic [CNT_W-1:0]   hl_m;
  logic [CNT_W-1:0]   tl_m;
  logic [CNT_W-1:0]   hl;
  logic [CNT_W-1:0]   tl;
  logic [CNT_W-1:0]   trl_start;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   trl_off;
  logic [MIDX_W-1:0]  hdr_k;
  logic [MIDX_W-1:0]  trl_k;
  logic [BYTE_W-1:0]  hdr_ref;
  logic [BYTE_W-1:0]  trl_ref;
  logic               match_ok;
  logic               wr_en;
  logic               rd_en;
  logic [BYTE_W-1:0]  rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_bytes_r <= '0;
      hdr_len_r   <= '0;
      trl_bytes_r <= '0;
      trl_len_r   <= '0;
      frm_len_r   <= CNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HEADER_BYTES:   hdr_bytes_r <= cfg_data;
        CFG_HEADER_LENGTH:  hdr_len_r   <= cfg_data[LEN_W-1:0];
        CFG_TRAILER_BYTES:  trl_bytes_r <= cfg_data;
        CFG_TRAILER_LENGTH: trl_len_r   <= cfg_data[LEN_W-1:0];
        CFG_FRAME_LENGTH:   frm_len_r   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective lengths: frame length held within one to the store depth,
  // marks held within the mark limit and the frame length.
  always_comb begin
    if (frm_len_r == '0) begin
      fl = CNT_W'(1);
    end else if (frm_len_r > CNT_W'(MAX_FRAME)) begin
      fl = CNT_W'(MAX_FRAME);
    end else begin
      fl = frm_len_r;
    end
    hl_m = (CNT_W'(hdr_len_r) > CNT_W'(MAX_MARK)) ? CNT_W'(MAX_MARK) : CNT_W'(hdr_len_r);
    tl_m = (CNT_W'(trl_len_r) > CNT_W'(MAX_MARK)) ? CNT_W'(MAX_MARK) : CNT_W'(trl_len_r);
    hl   = (hl_m > fl) ? fl : hl_m;
    tl   = (tl_m > fl) ? fl : tl_m;
    trl_start = fl - tl;
  end

  // Position of the incoming byte; a count left stale by a shorter frame
  // length restarts at zero.
  assign cnt_eff = (byte_count_r >= fl) ? '0 : byte_count_r;
  assign cnt_inc = cnt_eff + CNT_W'(1);
  assign trl_off = cnt_eff - trl_start;
  assign hdr_k   = cnt_eff[MIDX_W-1:0];
  assign trl_k   = trl_off[MIDX_W-1:0];
  assign hdr_ref = hdr_bytes_r[BYTE_W*hdr_k +: BYTE_W];
  assign trl_ref = trl_bytes_r[BYTE_W*trl_k +: BYTE_W];

  // Mark check: the header wins where header and trailer overlap.
  always_comb begin
    if (cnt_eff < hl) begin
      match_ok = (in_data.rx_byte == hdr_ref);
    end else if (cnt_eff >= trl_start) begin
      match_ok = (in_data.rx_byte == trl_ref);
    end else begin
      match_ok = 1'b1;
    end
  end

  assign sts.frame_done = !drop_r && match_ok && (cnt_inc == fl);

  // Count and drop flag updates for a taken byte.
  always_comb begin
    byte_count_nxt = byte_count_r;
    drop_nxt       = drop_r;
    if (cmd.take) begin
      if (drop_r) begin
        if (in_data.chunk_end) begin
          drop_nxt = 1'b0;
        end
      end else if (!match_ok) begin
        byte_count_nxt = '0;
      end else if (cnt_inc == fl) begin
        byte_count_nxt = '0;
        drop_nxt       = !in_data.chunk_end;
      end else begin
        byte_count_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      drop_r       <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      drop_r       <= drop_nxt;
    end
  end

  // Frame store: every byte outside a drop is written at its position.
  assign wr_en = cmd.take && !drop_r;

  // Dump read index walks the frame from position zero.
  assign rd_en      = cmd.rd_start || cmd.rd_next;
  assign rd_idx_nxt = cmd.rd_start ? '0 : (rd_idx_r + ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (rd_en) begin
      rd_idx_r <= rd_idx_nxt;
    end
  end

  htfs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (cnt_eff[ADDR_W-1:0]),
    .wr_data   (in_data.rx_byte),
    .rd_en     (rd_en),
    .rd_addr   (rd_idx_nxt),
    .rd_data_r (rd_data)
  );

  assign sts.rd_last = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == fl);

  // Result payload straight from the store's read register.
  assign out_data.frame_byte    = rd_data;
  assign out_data.byte_position = POS_W'(rd_idx_r);
  assign out_data.frame_last    = sts.rd_last;

endmodule

// File: hw/rtl/header_trailer_frame_sync_top.sv
// Top level of the header/trailer frame sync block.
//
// Input channel (in_valid, in_stall, in_data): one received byte per request,
// tagged with chunk_end. While collecting, a byte is taken every cycle.
// Result channel (out_valid, out_stall, out_data): one frame byte per request,
// with its position and a flag on the final byte of the frame.
// Configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data): always
// ready; registers are meant to be written while the block is idle.
// When the byte that completes a frame is taken, in_stall rises and stays
// high until the last frame byte is delivered. The first frame byte appears
// once the controller has passed from its read state to its emit state; then
// one byte per cycle follows while the receiver does not stall. The
// single read port of the frame store sets that dump rate.
// When the receiver stalls, the current frame byte holds and the dump waits.
// Reset (synchronous, active low) clears the count, the drop flag and the
// registers (frame length to one); the frame store needs no clearing.
module header_trailer_frame_sync_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  htfs_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output htfs_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [htfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  import htfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Registers take writes in any cycle.
  assign cfg_ready = 1'b1;

  htfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  htfs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: hw/rtl/htfs_checker.sv
// Port-level checks of the frame sync block and their binding to the top level.
`include "assert_macros.svh"

module htfs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input htfs_pkg::out_t out_data
);

  import htfs_pkg::*;

  // A stalled result request holds.
  `HTFS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // No byte is taken while a frame is being delivered.
  `HTFS_ASSERT(a_no_take_in_dump, clk, rst_n, out_valid |-> in_stall, "input open during frame dump")

  // A frame starts at position zero.
  `HTFS_ASSERT(a_frame_start, clk, rst_n, $rose(out_valid) |-> out_data.byte_position == '0, "frame did not start at position zero")

  // Frame bytes follow one another without gaps in position.
  `HTFS_ASSERT(a_frame_walk, clk, rst_n, out_valid && !out_stall && !out_data.frame_last |=> out_valid && (out_data.byte_position == ($past(out_data.byte_position) + 6'd1)), "frame positions not consecutive")

  // Reset leaves no result pending.
  `HTFS_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind header_trailer_frame_sync_top htfs_checker u_htfs_checker (.*);
